### rtl/core/pcu_pkg.sv
// Shared types and codes for the packed string compare unit.
package pcu_pkg;

  // Transfer payloads
  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         control;
    logic [63:0]        operand_a_low;
    logic [63:0]        operand_a_high;
    logic [63:0]        operand_b_low;
    logic [63:0]        operand_b_high;
    logic signed [31:0] length_a;
    logic signed [31:0] length_b;
  } in_t;

  typedef struct packed {
    logic [4:0]  found_index;
    logic [63:0] mask_low;
    logic [63:0] mask_high;
    logic        carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
  } out_t;

  // One element widened to 17 bits so signed and unsigned compare alike
  typedef logic signed [16:0] elem_t;

  // Command bits
  localparam int unsigned CMD_EXPLICIT_BIT = 0;
  localparam int unsigned CMD_MASK_BIT     = 1;

  // Aggregation codes (control bits 3:2)
  localparam logic [1:0] AGG_EQUAL_ANY     = 2'd0;
  localparam logic [1:0] AGG_RANGES        = 2'd1;
  localparam logic [1:0] AGG_EQUAL_EACH    = 2'd2;
  localparam logic [1:0] AGG_EQUAL_ORDERED = 2'd3;

  // Polarity codes (control bits 5:4)
  localparam logic [1:0] POL_POSITIVE     = 2'd0;
  localparam logic [1:0] POL_NEGATE_ALL   = 2'd1;
  localparam logic [1:0] POL_MASKED_POS   = 2'd2;
  localparam logic [1:0] POL_NEGATE_VALID = 2'd3;

  // Element counts
  localparam logic [4:0] NUM_BYTES = 5'd16;
  localparam logic [4:0] NUM_WORDS = 5'd8;

endpackage

### rtl/core/packed_string_compare_unit.sv
// Packed string compare unit: four-stage pipeline from operands to index, mask and flags.
// A transfer moves through four register stages; out_valid is the stage 4 valid bit.
// One transfer per cycle if out_stall is low; the 16x16 compare matrix sets stage depth.
// Stages: lengths and elements, compare matrix, aggregation and polarity, index/mask.
// Reset: synchronous active-low rst_n clears all stage valid bits; payload is not reset.
// A stalled result holds in the output register while earlier stages keep filling.
module packed_string_compare_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pcu_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pcu_pkg::out_t  out_data
);
  import pcu_pkg::*;

  // ---------------- handshake ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !s4_valid_r || !out_stall;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
    end
  end

  // ---------------- stage 1: elements and lengths ----------------
  logic [127:0] op_a, op_b;
  logic         in_wide, in_sgn;
  logic [4:0]   in_n;
  elem_t        ea_nxt [16];
  elem_t        eb_nxt [16];
  logic [15:0]  a_zero, b_zero;
  logic [4:0]   imp_len_a, imp_len_b;
  logic [31:0]  mag_a, mag_b;
  logic [4:0]   exp_len_a, exp_len_b;

  assign op_a    = {in_data.operand_a_high, in_data.operand_a_low};
  assign op_b    = {in_data.operand_b_high, in_data.operand_b_low};
  assign in_wide = in_data.control[0];
  assign in_sgn  = in_data.control[1];
  assign in_n    = in_wide ? NUM_WORDS : NUM_BYTES;

  always_comb begin
    logic [7:0]  byte_a, byte_b;
    logic [15:0] word_a, word_b;
    for (int k = 0; k < 16; k++) begin
      byte_a = op_a[k*8 +: 8];
      byte_b = op_b[k*8 +: 8];
      word_a = op_a[(k & 7)*16 +: 16];
      word_b = op_b[(k & 7)*16 +: 16];
      if (in_wide) begin
        if (k < 8) begin
          ea_nxt[k] = {in_sgn & word_a[15], word_a};
          eb_nxt[k] = {in_sgn & word_b[15], word_b};
        end else begin
          ea_nxt[k] = '0;
          eb_nxt[k] = '0;
        end
        a_zero[k] = (word_a == 16'd0);
        b_zero[k] = (word_b == 16'd0);
      end else begin
        ea_nxt[k] = {{9{in_sgn & byte_a[7]}}, byte_a};
        eb_nxt[k] = {{9{in_sgn & byte_b[7]}}, byte_b};
        a_zero[k] = (byte_a == 8'd0);
        b_zero[k] = (byte_b == 8'd0);
      end
    end
  end

  // Implicit length: first zero element, element count if none
  always_comb begin
    imp_len_a = in_n;
    imp_len_b = in_n;
    for (int k = 15; k >= 0; k--) begin
      if (a_zero[k] && (5'(k) < in_n)) imp_len_a = 5'(k);
      if (b_zero[k] && (5'(k) < in_n)) imp_len_b = 5'(k);
    end
  end

  // Explicit length: absolute value saturated to the element count
  always_comb begin
    logic [31:0] raw_a, raw_b;
    raw_a = in_data.length_a;
    raw_b = in_data.length_b;
    mag_a = raw_a[31] ? (~raw_a + 32'd1) : raw_a;
    mag_b = raw_b[31] ? (~raw_b + 32'd1) : raw_b;
    exp_len_a = (mag_a > {27'd0, in_n}) ? in_n : mag_a[4:0];
    exp_len_b = (mag_b > {27'd0, in_n}) ? in_n : mag_b[4:0];
  end

  elem_t      s1_ea_r [16];
  elem_t      s1_eb_r [16];
  logic [4:0] s1_len_a_r, s1_len_b_r;
  logic [7:0] s1_ctl_r;
  logic [1:0] s1_cmd_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ea_r    <= ea_nxt;
      s1_eb_r    <= eb_nxt;
      s1_len_a_r <= in_data.command[CMD_EXPLICIT_BIT] ? exp_len_a : imp_len_a;
      s1_len_b_r <= in_data.command[CMD_EXPLICIT_BIT] ? exp_len_b : imp_len_b;
      s1_ctl_r   <= in_data.control;
      s1_cmd_r   <= in_data.command;
    end
  end

  // ---------------- stage 2: compare matrix ----------------
  logic [1:0]             s1_agg;
  logic [4:0]             s1_n;
  logic [15:0][15:0]      mat_nxt;   // [j = B index][i = A index]

  assign s1_agg = s1_ctl_r[3:2];
  assign s1_n   = s1_ctl_r[0] ? NUM_WORDS : NUM_BYTES;

  always_comb begin
    logic va, vb;
    for (int j = 0; j < 16; j++) begin
      for (int i = 0; i < 16; i++) begin
        va = 5'(i) < s1_len_a_r;
        vb = 5'(j) < s1_len_b_r;
        if (va && vb) begin
          if (s1_agg == AGG_RANGES) begin
            // odd A elements are upper bounds, even ones lower bounds
            mat_nxt[j][i] = (i % 2 == 1) ? (s1_eb_r[j] <= s1_ea_r[i])
                                         : (s1_eb_r[j] >= s1_ea_r[i]);
          end else begin
            mat_nxt[j][i] = (s1_eb_r[j] == s1_ea_r[i]);
          end
        end else if (va) begin
          mat_nxt[j][i] = 1'b0;
        end else if (vb) begin
          mat_nxt[j][i] = (s1_agg == AGG_EQUAL_ORDERED);
        end else begin
          mat_nxt[j][i] = (s1_agg == AGG_EQUAL_EACH) || (s1_agg == AGG_EQUAL_ORDERED);
        end
      end
    end
  end

  logic [15:0][15:0] s2_mat_r;
  logic [7:0]        s2_ctl_r;
  logic [1:0]        s2_cmd_r;
  logic [4:0]        s2_len_b_r;
  logic              s2_zf_r, s2_sf_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_mat_r   <= mat_nxt;
      s2_ctl_r   <= s1_ctl_r;
      s2_cmd_r   <= s1_cmd_r;
      s2_len_b_r <= s1_len_b_r;
      s2_zf_r    <= s1_len_b_r < s1_n;
      s2_sf_r    <= s1_len_a_r < s1_n;
    end
  end

  // ---------------- stage 3: aggregation and polarity ----------------
  logic [1:0]  s2_agg, s2_pol;
  logic [4:0]  s2_n;
  logic [15:0] n_mask;
  logic [15:0] agg_res, pol_res;
  logic [16:0] len_b_mask;

  assign s2_agg     = s2_ctl_r[3:2];
  assign s2_pol     = s2_ctl_r[5:4];
  assign s2_n       = s2_ctl_r[0] ? NUM_WORDS : NUM_BYTES;
  assign n_mask     = s2_ctl_r[0] ? 16'h00FF : 16'hFFFF;
  assign len_b_mask = (17'd1 << s2_len_b_r) - 17'd1;

  always_comb begin
    logic v;
    agg_res = '0;
    for (int j = 0; j < 16; j++) begin
      case (s2_agg)
        AGG_EQUAL_ANY: begin
          agg_res[j] = |(s2_mat_r[j] & n_mask);
        end
        AGG_RANGES: begin
          v = 1'b0;
          for (int p = 0; p < 8; p++) begin
            if (5'(2*p + 1) < s2_n) v = v | (s2_mat_r[j][2*p] & s2_mat_r[j][2*p + 1]);
          end
          agg_res[j] = v;
        end
        AGG_EQUAL_EACH: begin
          agg_res[j] = s2_mat_r[j][j];
        end
        default: begin
          // equal-ordered: walk the diagonal starting at B element j
          v = 1'b1;
          for (int i = 0; i < 16; i++) begin
            if (i + j < 16) begin
              if (5'(i + j) < s2_n) v = v & s2_mat_r[i + j][i];
            end
          end
          agg_res[j] = v;
        end
      endcase
    end
  end

  always_comb begin
    case (s2_pol)
      POL_NEGATE_ALL:   pol_res = ~agg_res;
      POL_NEGATE_VALID: pol_res = agg_res ^ len_b_mask[15:0];
      default:          pol_res = agg_res;
    endcase
  end

  logic [15:0] s3_res_r;
  logic        s3_wide_r, s3_sel_r, s3_mask_cmd_r, s3_zf_r, s3_sf_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_res_r      <= pol_res & n_mask;
      s3_wide_r     <= s2_ctl_r[0];
      s3_sel_r      <= s2_ctl_r[6];
      s3_mask_cmd_r <= s2_cmd_r[CMD_MASK_BIT];
      s3_zf_r       <= s2_zf_r;
      s3_sf_r       <= s2_sf_r;
    end
  end

  // ---------------- stage 4: index, mask and flags ----------------
  logic [4:0]   idx_lo, idx_hi;
  logic [127:0] exp_mask;
  out_t         res_nxt;

  always_comb begin
    idx_lo = s3_wide_r ? NUM_WORDS : NUM_BYTES;
    idx_hi = s3_wide_r ? NUM_WORDS : NUM_BYTES;
    for (int k = 15; k >= 0; k--) begin
      if (s3_res_r[k]) idx_lo = 5'(k);
    end
    for (int k = 0; k < 16; k++) begin
      if (s3_res_r[k]) idx_hi = 5'(k);
    end
  end

  always_comb begin
    exp_mask = '0;
    for (int k = 0; k < 16; k++) begin
      if (s3_wide_r) begin
        if (k < 8) exp_mask[(k & 7)*16 +: 16] = {16{s3_res_r[k]}};
      end else begin
        exp_mask[k*8 +: 8] = {8{s3_res_r[k]}};
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    if (s3_mask_cmd_r) begin
      if (s3_sel_r) begin
        res_nxt.mask_low  = exp_mask[63:0];
        res_nxt.mask_high = exp_mask[127:64];
      end else begin
        res_nxt.mask_low  = {48'd0, s3_res_r};
      end
    end else begin
      res_nxt.found_index = s3_sel_r ? idx_hi : idx_lo;
    end
    res_nxt.carry_flag    = |s3_res_r;
    res_nxt.zero_flag     = s3_zf_r;
    res_nxt.sign_flag     = s3_sf_r;
    res_nxt.overflow_flag = s3_res_r[0];
  end

  out_t s4_out_r;

  always_ff @(posedge clk) begin
    if (rdy4) s4_out_r <= res_nxt;
  end

  assign out_valid = s4_valid_r;
  assign out_data  = s4_out_r;

  // ---------------- assertions ----------------
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled while first stage is empty");

  a_of_implies_cf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow_flag |-> out_data.carry_flag)
    else $error("overflow flag set without carry flag");

  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.carry_flag |->
      (out_data.mask_low == 64'd0) && (out_data.mask_high == 64'd0))
    else $error("mask bits set with empty result");

  a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.carry_flag |->
      (out_data.found_index == 5'd0) || (out_data.found_index == NUM_WORDS) ||
      (out_data.found_index == NUM_BYTES))
    else $error("index points at a bit of an empty result");

endmodule
